// ===== hw/rtl/ecrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ecrs_pkg
// Shared types and constants of the extent chunk request splitter.
// ----------------------------------------------------------------------------
package ecrs_pkg;

  localparam int PAGE_W    = 32;
  localparam int OFFSET_W  = 48;
  localparam int BYTES_W   = 23;
  localparam int ADDR_W    = 64;
  localparam int CHUNK_W   = 17;
  localparam int MEDIA_W   = 2;
  localparam int PCOUNT_W  = 7;
  localparam int ECOUNT_W  = 5;
  localparam int EIDX_W    = 4;
  localparam int WCOUNT_W  = 7;
  localparam int WIDX_W    = 6;

  localparam int MAX_EXTENTS_DEF = 16;

  localparam logic [PCOUNT_W-1:0] MAX_PAGES_PER_REQUEST = 7'd64;
  localparam logic [WCOUNT_W-1:0] WORKER_MAX            = 7'd64;
  localparam logic [BYTES_W-1:0]  BYTES_ISSUED_MAX      = 23'h7FFFFF;
  localparam logic [CHUNK_W-1:0]  PIECE_MAX             = 17'h1FFFF;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ISSUE = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [EIDX_W-1:0]   extent_index;
    logic [PAGE_W-1:0]   extent_first_page;
    logic [PAGE_W-1:0]   extent_last_page;
    logic [ECOUNT_W-1:0] extent_count;
    logic [PAGE_W-1:0]   start_page;
    logic [PCOUNT_W-1:0] page_count;
    logic [OFFSET_W-1:0] file_offset;
    logic [BYTES_W-1:0]  byte_count;
    logic [ADDR_W-1:0]   buffer_base;
    logic [CHUNK_W-1:0]  chunk_bytes;
    logic [MEDIA_W-1:0]  media_kind;
  } in_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_number;
    logic [WIDX_W-1:0]   worker_index;
    logic [ADDR_W-1:0]   piece_address;
    logic [OFFSET_W-1:0] piece_offset;
    logic [CHUNK_W-1:0]  piece_bytes;
    logic [MEDIA_W-1:0]  piece_media;
    logic                last_piece;
  } out_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] first_page;
    logic [PAGE_W-1:0] last_page;
  } ext_ent_t;

endpackage

// ===== hw/rtl/ecrs_ram.sv =====
// ----------------------------------------------------------------------------
// ecrs_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ecrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/extent_chunk_request_splitter_core.sv =====
// ----------------------------------------------------------------------------
// extent_chunk_request_splitter_core
// Splits one file request into per-page requests along a loaded extent table.
// ----------------------------------------------------------------------------
//  channel  handshake        payload    carries
//  in_      valid / stall    in_req_t   extent load or issue request
//  out_     valid / stall    out_req_t  one per-page request
//  cfg_     valid / ready    7 bits     worker count
//
// An issue first gets the offset remainder, then walks past the extents that
// end before the start page, fetches extent data and gets the worker remainder,
// then emits one request per page; each jump to a new extent fetches extent
// data and worker remainder anew. All remainders come from one bit-serial unit.
// Reset is synchronous; the extent table holds no reset value.
// A stalled output holds its request; the page walk waits on it.
// ----------------------------------------------------------------------------
module extent_chunk_request_splitter_core
  import ecrs_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_req_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_req_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WCOUNT_W-1:0] cfg_data
);

  localparam int EXT_AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int EXT_CW = $clog2(MAX_EXTENTS + 1);
  localparam int DIV_W  = OFFSET_W;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_OFF,
    S_SKIP_RD,
    S_SKIP_CHK,
    S_CUR_RD,
    S_CUR_LAT,
    S_NXT_RD,
    S_NXT_LAT,
    S_MOD,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [WCOUNT_W-1:0] worker_count_r;
  logic [EXT_CW-1:0]   ext_cnt_r;
  logic [EXT_CW-1:0]   cur_ext_r;
  logic [PAGE_W-1:0]   page_r;
  logic [PCOUNT_W-1:0] pages_left_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [BYTES_W-1:0]  total_r;
  logic [ADDR_W-1:0]   base_r;
  logic [CHUNK_W-1:0]  chunk_r;
  logic [MEDIA_W-1:0]  media_r;
  logic [BYTES_W-1:0]  issued_r;
  logic                first_r;
  logic [CHUNK_W-1:0]  within_r;
  logic [WIDX_W-1:0]   worker_r;
  logic [PAGE_W-1:0]   cur_last_r;
  logic [PAGE_W-1:0]   next_first_r;
  logic [CHUNK_W-1:0]  div_rem_r;
  logic [DIV_W-1:0]    div_shift_r;
  logic [CNT_W-1:0]    div_cnt_r;
  logic [CHUNK_W-1:0]  divisor_r;
  logic                out_valid_r;
  out_req_t            out_r;

  // bit-serial remainder step
  logic [CHUNK_W:0]   div_trial;
  logic [CHUNK_W:0]   div_sub;
  logic [CHUNK_W-1:0] div_rem_nxt;

  assign div_trial   = {div_rem_r, div_shift_r[DIV_W-1]};
  assign div_sub     = div_trial - {1'b0, divisor_r};
  assign div_rem_nxt = (div_trial >= {1'b0, divisor_r}) ? div_sub[CHUNK_W-1:0]
                                                        : div_trial[CHUNK_W-1:0];

  logic [WCOUNT_W-1:0] workers_eff;

  always_comb begin
    priority if (worker_count_r == '0) begin
      workers_eff = WCOUNT_W'(1);
    end else if (worker_count_r > WORKER_MAX) begin
      workers_eff = WORKER_MAX;
    end else begin
      workers_eff = worker_count_r;
    end
  end

  // extent table
  logic [31:0]                 load_idx32;
  logic                        ram_we;
  logic [EXT_AW-1:0]           ram_raddr;
  logic [$bits(ext_ent_t)-1:0] ram_rdata;
  ext_ent_t                    ram_wdata;
  ext_ent_t                    ent;
  logic [EXT_CW:0]             nxt_ext;
  logic                        in_take;

  assign in_take    = in_valid && !in_stall;
  assign load_idx32 = 32'(in_data.extent_index);
  assign ram_we     = in_take && (in_data.operation == OP_LOAD) &&
                      (load_idx32 < 32'(MAX_EXTENTS));
  assign ram_wdata  = '{first_page: in_data.extent_first_page,
                        last_page:  in_data.extent_last_page};
  assign nxt_ext    = {1'b0, cur_ext_r} + (EXT_CW + 1)'(1);
  assign ram_raddr  = (state_r == S_NXT_RD) ? nxt_ext[EXT_AW-1:0] : cur_ext_r[EXT_AW-1:0];
  assign ent        = ext_ent_t'(ram_rdata);

  ecrs_ram #(
    .WIDTH ($bits(ext_ent_t)),
    .DEPTH (MAX_EXTENTS)
  ) u_ext_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (load_idx32[EXT_AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // issue request setup
  logic [CHUNK_W-1:0]  chunk_eff;
  logic [PCOUNT_W-1:0] pages_eff;
  logic [EXT_CW-1:0]   ext_cnt_eff;

  assign chunk_eff   = (in_data.chunk_bytes == '0) ? CHUNK_W'(1) : in_data.chunk_bytes;
  assign pages_eff   = (in_data.page_count > MAX_PAGES_PER_REQUEST) ? MAX_PAGES_PER_REQUEST
                                                                    : in_data.page_count;
  assign ext_cnt_eff = (32'(in_data.extent_count) > 32'(MAX_EXTENTS)) ? EXT_CW'(MAX_EXTENTS)
                                                                      : EXT_CW'(in_data.extent_count);

  // per-page request
  logic [BYTES_W:0]    sum_first;
  logic [BYTES_W:0]    piece_raw;
  logic [CHUNK_W-1:0]  piece;
  logic [BYTES_W:0]    issued_sum;
  logic [BYTES_W-1:0]  issued_nxt;
  logic [PAGE_W-1:0]   page_inc;
  logic [WIDX_W-1:0]   worker_inc;
  logic                jump;
  logic                emit_go;

  always_comb begin
    sum_first = {1'b0, total_r} + (BYTES_W + 1)'(within_r);
    priority if (first_r) begin
      if ((BYTES_W + 1)'(chunk_r) < sum_first) begin
        piece_raw = (BYTES_W + 1)'(chunk_r - within_r);
      end else begin
        piece_raw = {1'b0, total_r};
      end
    end else if (pages_left_r == PCOUNT_W'(1)) begin
      piece_raw = (total_r > issued_r) ? {1'b0, total_r - issued_r} : '0;
    end else begin
      piece_raw = (BYTES_W + 1)'(chunk_r);
    end
    piece      = (piece_raw > (BYTES_W + 1)'(PIECE_MAX)) ? PIECE_MAX
                                                         : piece_raw[CHUNK_W-1:0];
    issued_sum = {1'b0, issued_r} + (BYTES_W + 1)'(piece);
    issued_nxt = (issued_sum > {1'b0, BYTES_ISSUED_MAX}) ? BYTES_ISSUED_MAX
                                                         : issued_sum[BYTES_W-1:0];
  end

  assign page_inc   = page_r + PAGE_W'(1);
  assign worker_inc = ((page_inc == '0) ||
                       ((WCOUNT_W'(worker_r) + WCOUNT_W'(1)) == workers_eff)) ? '0
                                                                              : worker_r + WIDX_W'(1);
  assign jump       = (cur_ext_r < ext_cnt_r) && (page_inc > cur_last_r) &&
                      (nxt_ext < {1'b0, ext_cnt_r});
  assign emit_go    = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      worker_count_r <= WCOUNT_W'(1);
      out_valid_r    <= 1'b0;
      cur_ext_r      <= '0;
      page_r         <= '0;
      pages_left_r   <= '0;
      issued_r       <= '0;
      first_r        <= 1'b1;
      div_cnt_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        worker_count_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && !emit_go) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take && (in_data.operation == OP_ISSUE) && (pages_eff != '0)) begin
            ext_cnt_r    <= ext_cnt_eff;
            cur_ext_r    <= '0;
            page_r       <= in_data.start_page;
            pages_left_r <= pages_eff;
            offset_r     <= in_data.file_offset;
            total_r      <= in_data.byte_count;
            base_r       <= in_data.buffer_base;
            chunk_r      <= chunk_eff;
            media_r      <= in_data.media_kind;
            issued_r     <= '0;
            first_r      <= 1'b1;
            divisor_r    <= chunk_eff;
            div_shift_r  <= in_data.file_offset;
            div_rem_r    <= '0;
            div_cnt_r    <= CNT_W'(OFFSET_W);
            state_r      <= S_DIV_OFF;
          end
        end
        S_DIV_OFF: begin
          if (div_cnt_r == '0) begin
            within_r <= div_rem_r;
            state_r  <= S_SKIP_RD;
          end else begin
            div_rem_r   <= div_rem_nxt;
            div_shift_r <= {div_shift_r[DIV_W-2:0], 1'b0};
            div_cnt_r   <= div_cnt_r - CNT_W'(1);
          end
        end
        S_SKIP_RD: begin
          state_r <= S_SKIP_CHK;
        end
        S_SKIP_CHK: begin
          cur_last_r <= ent.last_page;
          if ((cur_ext_r < ext_cnt_r) && (page_r > ent.last_page)) begin
            cur_ext_r <= cur_ext_r + EXT_CW'(1);
            state_r   <= S_SKIP_RD;
          end else begin
            state_r <= S_NXT_RD;
          end
        end
        S_CUR_RD: begin
          state_r <= S_CUR_LAT;
        end
        S_CUR_LAT: begin
          cur_last_r <= ent.last_page;
          state_r    <= S_NXT_RD;
        end
        S_NXT_RD: begin
          state_r <= S_NXT_LAT;
        end
        S_NXT_LAT: begin
          next_first_r <= ent.first_page;
          divisor_r    <= CHUNK_W'(workers_eff);
          div_shift_r  <= {page_r, {(DIV_W - PAGE_W){1'b0}}};
          div_rem_r    <= '0;
          div_cnt_r    <= CNT_W'(PAGE_W);
          state_r      <= S_MOD;
        end
        S_MOD: begin
          if (div_cnt_r == '0) begin
            worker_r <= div_rem_r[WIDX_W-1:0];
            state_r  <= S_EMIT;
          end else begin
            div_rem_r   <= div_rem_nxt;
            div_shift_r <= {div_shift_r[DIV_W-2:0], 1'b0};
            div_cnt_r   <= div_cnt_r - CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r         <= 1'b1;
            out_r.page_number   <= page_r;
            out_r.worker_index  <= worker_r;
            out_r.piece_address <= base_r + ADDR_W'(issued_r);
            out_r.piece_offset  <= offset_r + OFFSET_W'(issued_r);
            out_r.piece_bytes   <= piece;
            out_r.piece_media   <= media_r;
            out_r.last_piece    <= (pages_left_r == PCOUNT_W'(1));
            issued_r            <= issued_nxt;
            first_r             <= 1'b0;
            pages_left_r        <= pages_left_r - PCOUNT_W'(1);
            priority if (pages_left_r == PCOUNT_W'(1)) begin
              state_r <= S_IDLE;
            end else if (jump) begin
              cur_ext_r <= cur_ext_r + EXT_CW'(1);
              page_r    <= next_first_r;
              state_r   <= S_CUR_RD;
            end else begin
              page_r   <= page_inc;
              worker_r <= worker_inc;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_emit_has_pages: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> pages_left_r != '0)
    else $error("page walk active with no pages left");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_OFF || state_r == S_MOD) |-> div_rem_r < divisor_r)
    else $error("remainder unit out of range");

  a_worker_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> WCOUNT_W'(worker_r) < workers_eff)
    else $error("worker index not below worker count");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && pages_left_r == PCOUNT_W'(1)
    |=> state_r == S_IDLE && out_valid_r && out_r.last_piece)
    else $error("final request did not end the walk");

endmodule

// ===== verif/extent_chunk_request_splitter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extent_chunk_request_splitter_core_tb
// Self-checking bench for the extent chunk request splitter.
//
// Loads extent tables and issues file requests through the input channel.
// Every accepted request feeds a behavioral page splitter that queues the
// per-page requests it should produce. Each request leaving the block is
// compared field by field against the oldest queued one. Both channels idle
// at random, except for one phase that runs at full rate. The worker count
// changes between phases while the block is idle.
// ----------------------------------------------------------------------------
module extent_chunk_request_splitter_core_tb;
  import ecrs_pkg::*;

  localparam int PHASE_ITEMS   = 80;
  localparam int SETTLE_CYCLES = 300;
  localparam int IDLE_PCT      = 28;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_req_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_req_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WCOUNT_W-1:0] cfg_data  = '0;

  in_req_t  pending_reqs[$];
  out_req_t pieces_due[$];
  out_req_t head_piece;

  logic [PAGE_W-1:0]   ext_first_mem [MAX_EXTENTS_DEF];
  logic [PAGE_W-1:0]   ext_last_mem  [MAX_EXTENTS_DEF];
  logic [WCOUNT_W-1:0] worker_setting = 7'd1;

  logic [PAGE_W-1:0]          plan_first [MAX_EXTENTS_DEF];
  logic [MAX_EXTENTS_DEF-1:0] plan_loaded = '0;

  logic no_idle       = 1'b0;
  int   fail_count    = 0;
  int   req_count     = 0;
  int   issue_count   = 0;
  int   piece_count   = 0;
  int   setting_count = 0;

  extent_chunk_request_splitter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic split_request(input in_req_t r);
    int unsigned       ext_n;
    int unsigned       ext_i;
    int unsigned       left;
    int unsigned       workers;
    logic              first;
    logic [PAGE_W-1:0] page;
    logic [63:0]       off;
    logic [63:0]       total;
    logic [63:0]       chunk;
    logic [63:0]       issued;
    logic [63:0]       chunk_rem;
    logic [63:0]       piece;
    out_req_t          p;
    if (r.operation == OP_LOAD) begin
      ext_first_mem[r.extent_index] = r.extent_first_page;
      ext_last_mem[r.extent_index]  = r.extent_last_page;
    end else begin
      ext_n   = (r.extent_count > MAX_EXTENTS_DEF) ? MAX_EXTENTS_DEF : r.extent_count;
      left    = (r.page_count > MAX_PAGES_PER_REQUEST) ? MAX_PAGES_PER_REQUEST : r.page_count;
      page    = r.start_page;
      off     = r.file_offset;
      total   = r.byte_count;
      chunk   = (r.chunk_bytes == '0) ? 64'd1 : r.chunk_bytes;
      workers = (worker_setting == '0) ? 1 :
                (worker_setting > WORKER_MAX) ? WORKER_MAX : worker_setting;
      issued  = '0;
      first   = 1'b1;
      ext_i   = 0;
      // skip extents that end before the start page
      while (ext_i < ext_n && page > ext_last_mem[ext_i]) ext_i++;
      while (left > 0) begin
        if (first) begin
          chunk_rem = off % chunk;
          first     = 1'b0;
          piece     = (chunk < total + chunk_rem) ? chunk - chunk_rem : total;
        end else if (left == 1) begin
          piece = (total > issued) ? total - issued : 64'd0;
        end else begin
          piece = chunk;
        end
        if (piece > PIECE_MAX) piece = PIECE_MAX;
        p.page_number   = page;
        p.worker_index  = WIDX_W'(page % workers);
        p.piece_address = r.buffer_base + issued;
        p.piece_offset  = OFFSET_W'(off + issued);
        p.piece_bytes   = CHUNK_W'(piece);
        p.piece_media   = r.media_kind;
        p.last_piece    = (left == 1);
        pieces_due.push_back(p);
        issued = (issued + piece > BYTES_ISSUED_MAX) ? BYTES_ISSUED_MAX : issued + piece;
        page   = page + 1'b1;
        left--;
        // jump to the next extent once past the current one
        if (ext_i < ext_n && page > ext_last_mem[ext_i] && ext_i + 1 < ext_n) begin
          ext_i++;
          page = ext_first_mem[ext_i];
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        split_request(in_data);
        req_count++;
        if (in_data.operation == OP_ISSUE) issue_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pieces_due.size() == 0) begin
          $display("%0t: request with none expected, expected nothing, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          head_piece = pieces_due.pop_front();
          piece_count++;
          check_field("page_number", head_piece.page_number, out_data.page_number);
          check_field("worker_index", head_piece.worker_index, out_data.worker_index);
          check_field("piece_address", head_piece.piece_address, out_data.piece_address);
          check_field("piece_offset", head_piece.piece_offset, out_data.piece_offset);
          check_field("piece_bytes", head_piece.piece_bytes, out_data.piece_bytes);
          check_field("piece_media", head_piece.piece_media, out_data.piece_media);
          check_field("last_piece", head_piece.last_piece, out_data.last_piece);
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic in_req_t noise_req();
    logic [319:0] bits;
    for (int i = 0; i < 10; i++) bits[i*32 +: 32] = $urandom();
    return bits[$bits(in_req_t)-1:0];
  endfunction

  function automatic void plan_load(input logic [EIDX_W-1:0] idx,
                                    input logic [PAGE_W-1:0] first_pg,
                                    input logic [PAGE_W-1:0] last_pg);
    in_req_t r;
    r                   = noise_req();
    r.operation         = OP_LOAD;
    r.extent_index      = idx;
    r.extent_first_page = first_pg;
    r.extent_last_page  = last_pg;
    pending_reqs.push_back(r);
    plan_first[idx]  = first_pg;
    plan_loaded[idx] = 1'b1;
  endfunction

  function automatic void plan_issue(input logic [ECOUNT_W-1:0] ext,
                                     input logic [PAGE_W-1:0]   start,
                                     input logic [PCOUNT_W-1:0] pages,
                                     input logic [OFFSET_W-1:0] off,
                                     input logic [BYTES_W-1:0]  bytes,
                                     input logic [ADDR_W-1:0]   base,
                                     input logic [CHUNK_W-1:0]  chunk,
                                     input logic [MEDIA_W-1:0]  media);
    in_req_t r;
    r              = noise_req();
    r.operation    = OP_ISSUE;
    r.extent_count = ext;
    r.start_page   = start;
    r.page_count   = pages;
    r.file_offset  = off;
    r.byte_count   = bytes;
    r.buffer_base  = base;
    r.chunk_bytes  = chunk;
    r.media_kind   = media;
    pending_reqs.push_back(r);
  endfunction

  function automatic int unsigned loaded_span();
    int unsigned n;
    n = 0;
    while (n < MAX_EXTENTS_DEF && plan_loaded[n]) n++;
    return n;
  endfunction

  task automatic plan_table();
    logic [PAGE_W-1:0] next_pg;
    int unsigned       len;
    next_pg = ($urandom_range(9) == 0) ? 32'hFFFF_FF00 : $urandom();
    for (int i = 0; i < MAX_EXTENTS_DEF; i++) begin
      len = $urandom_range(1, 8);
      plan_load(EIDX_W'(i), next_pg, next_pg + len - 1);
      next_pg = next_pg + len + $urandom_range(0, 20);
    end
  endtask

  task automatic random_issue();
    in_req_t     r;
    int unsigned span;
    int unsigned ext_n;
    int unsigned k;
    int unsigned sel;
    int unsigned pages;
    logic [63:0] chunk;
    logic [63:0] bytes;
    r           = noise_req();
    r.operation = OP_ISSUE;
    span        = loaded_span();
    if (span == MAX_EXTENTS_DEF && $urandom_range(9) == 0) begin
      r.extent_count = ECOUNT_W'($urandom_range(MAX_EXTENTS_DEF + 1, 31));
    end else begin
      r.extent_count = ECOUNT_W'($urandom_range(0, span));
    end
    ext_n = (r.extent_count > MAX_EXTENTS_DEF) ? MAX_EXTENTS_DEF : r.extent_count;
    if (ext_n != 0 && $urandom_range(9) < 8) begin
      k            = $urandom_range(0, ext_n - 1);
      r.start_page = plan_first[k] + $urandom_range(0, 10) - 2;
    end else if ($urandom_range(7) == 0) begin
      r.start_page = 32'hFFFF_FFFF - $urandom_range(0, 5);
    end else begin
      r.start_page = $urandom();
    end
    sel = $urandom_range(99);
    if (sel < 5) begin
      pages = 0;
    end else if (sel < 9) begin
      pages = $urandom_range(64, 127);
    end else if (sel < 16) begin
      pages = $urandom_range(9, 63);
    end else begin
      pages = $urandom_range(1, 8);
    end
    r.page_count = PCOUNT_W'(pages);
    case ($urandom_range(19))
      0:       r.chunk_bytes = '0;
      1:       r.chunk_bytes = CHUNK_W'($urandom_range(65537, 131071));
      2:       r.chunk_bytes = 17'd65536;
      3, 4, 5: r.chunk_bytes = CHUNK_W'($urandom_range(1, 65535));
      default: r.chunk_bytes = 17'd512 << $urandom_range(0, 4);
    endcase
    chunk = (r.chunk_bytes == '0) ? 64'd1 : r.chunk_bytes;
    if ($urandom_range(1) == 0) begin
      r.file_offset = OFFSET_W'(chunk * $urandom_range(0, 1000));
    end else begin
      r.file_offset = OFFSET_W'({$urandom(), $urandom()});
    end
    if ($urandom_range(4) == 0) begin
      r.byte_count = BYTES_W'($urandom());
    end else begin
      bytes = ((pages > MAX_PAGES_PER_REQUEST) ? MAX_PAGES_PER_REQUEST : pages) * chunk;
      if (bytes >= chunk) bytes = bytes - $urandom_range(0, chunk - 1);
      r.byte_count = (bytes > BYTES_ISSUED_MAX) ? BYTES_ISSUED_MAX : bytes[BYTES_W-1:0];
    end
    r.buffer_base = {$urandom(), $urandom()};
    r.media_kind  = ($urandom_range(19) == 0) ? 2'd3 : MEDIA_W'($urandom_range(0, 2));
    pending_reqs.push_back(r);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned       made;
    int unsigned       sel;
    logic [EIDX_W-1:0] idx;
    logic [PAGE_W-1:0] base_pg;
    made = 0;
    while (made < count) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        plan_table();
        made += MAX_EXTENTS_DEF;
      end else if (sel < 8) begin
        plan_load(EIDX_W'($urandom_range(0, 15)), $urandom(), $urandom());
        made++;
      end else if (sel < 12) begin
        idx     = EIDX_W'($urandom_range(0, 15));
        base_pg = plan_loaded[idx] ? plan_first[idx] : $urandom();
        plan_load(idx, base_pg, base_pg + $urandom_range(0, 7));
        made++;
      end else begin
        random_issue();
        made++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending_reqs.size() != 0 || in_valid || pieces_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_workers(input logic [WCOUNT_W-1:0] value);
    @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    worker_setting = value;
    setting_count++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    plan_load(4'd0, 32'd100, 32'd103);
    plan_load(4'd1, 32'd200, 32'd201);
    plan_load(4'd2, 32'd300, 32'd309);
    plan_load(4'd3, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    plan_issue(5'd0, 32'd0, 7'd0, 48'd0, 23'd0, 64'd0, 17'd1, 2'd0);
    plan_issue(5'd0, 32'hFFFF_FFFE, 7'd4, 48'hFFFF_FFFF_FFFF, 23'd0,
               64'hFFFF_FFFF_FFFF_FFFF, 17'd0, 2'd3);
    plan_issue(5'd4, 32'd101, 7'd12, 48'd1000, 23'd40000, 64'h1000, 17'd4096, 2'd1);
    plan_issue(5'd2, 32'd500, 7'd3, 48'd0, 23'd1536, 64'd0, 17'd512, 2'd2);
    plan_issue(5'd4, 32'd50, 7'd6, 48'd7, 23'd6000, 64'hFFFF_FFFF_FFFF_F000, 17'd1024, 2'd0);
    plan_issue(5'd4, 32'd309, 7'd2, 48'd0, 23'h7FFFFF, 64'd0, 17'd1, 2'd1);
    plan_issue(5'd4, 32'hFFFF_FFFE, 7'd3, 48'd0, 23'd100, 64'd0, 17'd4096, 2'd2);
    plan_issue(5'd4, 32'd102, 7'd127, 48'd0, 23'h7FFFFF, 64'h8000_0000_0000_0000,
               17'h1FFFF, 2'd0);
    plan_issue(5'd1, 32'd100, 7'd1, 48'h1234, 23'd300, 64'd5, 17'd4096, 2'd1);
    plan_issue(5'd4, 32'd300, 7'd64, 48'd0, 23'd4194304, 64'd0, 17'd65536, 2'd2);
    wait_idle();

    write_workers(7'd0);
    plan_table();
    random_phase(PHASE_ITEMS);
    wait_idle();

    write_workers(WORKER_MAX);
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    wait_idle();
    no_idle = 1'b0;

    write_workers(7'd127);
    random_phase(PHASE_ITEMS);
    wait_idle();

    write_workers(7'd1);
    random_phase(PHASE_ITEMS);
    wait_idle();

    write_workers(WCOUNT_W'($urandom_range(2, 63)));
    random_phase(PHASE_ITEMS);
    wait_idle();

    $display("Run: %0d requests in (%0d issues, %0d extent loads), %0d worker counts written",
             req_count, issue_count, req_count - issue_count, setting_count);
    $display("Run: %0d per-page requests compared, %0d mismatches, %0d never arrived",
             piece_count, fail_count, pieces_due.size());
    if (fail_count == 0 && pieces_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
